// ----- rtl/core/rwsa_pkg.sv -----
// Shared types and constants of the receive window with selective ack.
// Used by the channel interfaces, the shared adder and the top level.
package rwsa_pkg;

  // Sequence numbers, times and the ack bitmap fields are all 32 bits wide.
  localparam int unsigned SeqW       = 32;
  localparam int unsigned DelayW     = 16;

  // Number of sequence numbers above the gap that are tracked in the bitmap.
  localparam int unsigned AckWindow  = 32;
  localparam int unsigned IdxW       = $clog2(AckWindow);

  localparam logic [DelayW-1:0] AckDelayReset = 16'd25;

  typedef enum logic [1:0] {
    OpDatagram  = 2'd0,
    OpTick      = 2'd1,
    OpPiggyback = 2'd2,
    OpUnused    = 2'd3
  } rwsa_op_e;

  // Request to the shared 32-bit add/subtract unit.
  typedef struct packed {
    logic [SeqW-1:0] a;
    logic [SeqW-1:0] b;
    logic            sub;
  } alu_req_t;

  // Result of the shared unit; borrow is set when a subtract goes below zero.
  typedef struct packed {
    logic [SeqW-1:0] res;
    logic            borrow;
  } alu_rsp_t;

endpackage

// ----- rtl/core/rwsa_in_if.sv -----
// Input channel of the receive window: valid/ready handshake and one input item.
// Depends on rwsa_pkg for the field widths.
interface rwsa_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 opcode;
  logic [rwsa_pkg::SeqW-1:0]  seq;
  logic                       unordered;
  logic [rwsa_pkg::SeqW-1:0]  now_ms;

  modport source (output valid, output opcode, output seq, output unordered,
                  output now_ms, input ready);
  modport sink   (input valid, input opcode, input seq, input unordered,
                  input now_ms, output ready);
endinterface

// ----- rtl/core/rwsa_out_if.sv -----
// Result channel of the receive window: valid/ready handshake and one result item.
// Depends on rwsa_pkg for the field widths.
interface rwsa_out_if;
  logic                       valid;
  logic                       ready;
  logic                       is_new;
  logic                       is_duplicate;
  logic                       beyond_window;
  logic                       deliver_now;
  logic [rwsa_pkg::SeqW-1:0]  release_below;
  logic                       ack_valid;
  logic                       ack_standalone;
  logic [rwsa_pkg::SeqW-1:0]  ack_base;
  logic [rwsa_pkg::SeqW-1:0]  ack_bits;

  modport source (output valid, output is_new, output is_duplicate,
                  output beyond_window, output deliver_now, output release_below,
                  output ack_valid, output ack_standalone, output ack_base,
                  output ack_bits, input ready);
  modport sink   (input valid, input is_new, input is_duplicate,
                  input beyond_window, input deliver_now, input release_below,
                  input ack_valid, input ack_standalone, input ack_base,
                  input ack_bits, output ready);
endinterface

// ----- rtl/core/rwsa_addsub.sv -----
// Shared 32-bit add/subtract unit of the receive window sequencer.
// Depends on rwsa_pkg for the request and response types.
module rwsa_addsub (
  input  rwsa_pkg::alu_req_t req_i,
  output rwsa_pkg::alu_rsp_t rsp_o
);
  import rwsa_pkg::*;

  logic [SeqW:0] full;

  // One adder serves both directions; the extra top bit carries the borrow.
  always_comb begin
    if (req_i.sub) begin
      full = {1'b0, req_i.a} - {1'b0, req_i.b};
    end else begin
      full = {1'b0, req_i.a} + {1'b0, req_i.b};
    end
    rsp_o.res    = full[SeqW-1:0];
    rsp_o.borrow = req_i.sub & full[SeqW];
  end

endmodule

// ----- rtl/core/receive_window_selective_ack.sv -----
// Receive window with selective ack: one item at a time under a small sequencer.
// Each accepted item runs through StDiff, StClass and StDone, where its result
// goes into the output register; an in-order datagram also runs StAdv, which
// steps the shared 32-bit adder through consecutive numbers one per cycle.
// A new item is accepted only after the last has left StDone for StIdle.
// Reset (async, active low) clears the window, drops any pending ack, sets delay 25.
module receive_window_selective_ack (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rwsa_pkg::DelayW-1:0] cfg_data_i,
  rwsa_in_if.sink                     in_i,
  rwsa_out_if.source                  out_o
);
  import rwsa_pkg::*;

  // The sequencer walks each item through these steps. StDiff runs the one
  // subtract an item needs (seq minus next expected, or the age of the pending
  // ack). StClass decides from that difference. StAdv steps next expected up
  // by one per cycle while the bitmap shows consecutive received numbers.
  // StDone hands the result to the output register once it is free.
  typedef enum logic [2:0] {
    StIdle,
    StDiff,
    StClass,
    StAdv,
    StDone
  } state_e;

  state_e state_q, state_d;

  // Architectural state of the receive window.
  logic [SeqW-1:0]      next_exp_q, next_exp_d;
  logic [AckWindow-1:0] bitmap_q, bitmap_d;
  logic                 ack_wait_q, ack_wait_d;
  logic [SeqW-1:0]      wait_start_q, wait_start_d;
  logic [DelayW-1:0]    delay_q, delay_d;

  // The item being worked on.
  rwsa_op_e             op_q, op_d;
  logic [SeqW-1:0]      seq_q, seq_d;
  logic                 unord_q, unord_d;
  logic [SeqW-1:0]      now_q, now_d;
  logic [SeqW-1:0]      diff_q, diff_d;
  logic                 borrow_q, borrow_d;

  // Working result flags, built up while the item runs.
  logic                 new_q, new_d;
  logic                 dup_q, dup_d;
  logic                 beyond_q, beyond_d;
  logic                 ackv_q, ackv_d;
  logic                 stand_q, stand_d;
  logic [SeqW-1:0]      base_q, base_d;
  logic [SeqW-1:0]      bits_q, bits_d;

  // Output register; it lets the next item start while a result waits.
  logic                 ovalid_q, ovalid_d;
  logic                 onew_q, onew_d;
  logic                 odup_q, odup_d;
  logic                 obeyond_q, obeyond_d;
  logic                 odeliver_q, odeliver_d;
  logic [SeqW-1:0]      orelease_q, orelease_d;
  logic                 oackv_q, oackv_d;
  logic                 ostand_q, ostand_d;
  logic [SeqW-1:0]      obase_q, obase_d;
  logic [SeqW-1:0]      obits_q, obits_d;

  alu_req_t             alu_req;
  alu_rsp_t             alu_rsp;

  logic [IdxW-1:0]          slot_idx;
  logic [AckWindow+SeqW-1:0] bitmap_ext;

  rwsa_addsub u_addsub (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // A received number d above next expected lives in bitmap slot d-1. Only
  // the low index bits are needed, since the slot is used only for d in range.
  assign slot_idx   = IdxW'(diff_q[IdxW-1:0] - IdxW'(1));
  // The ack reports the low 32 bitmap bits, zero filled for a narrower window.
  assign bitmap_ext = {{SeqW{1'b0}}, bitmap_q};

  assign in_i.ready = (state_q == StIdle);

  always_comb begin
    state_d      = state_q;
    next_exp_d   = next_exp_q;
    bitmap_d     = bitmap_q;
    ack_wait_d   = ack_wait_q;
    wait_start_d = wait_start_q;
    delay_d      = delay_q;
    op_d         = op_q;
    seq_d        = seq_q;
    unord_d      = unord_q;
    now_d        = now_q;
    diff_d       = diff_q;
    borrow_d     = borrow_q;
    new_d        = new_q;
    dup_d        = dup_q;
    beyond_d     = beyond_q;
    ackv_d       = ackv_q;
    stand_d      = stand_q;
    base_d       = base_q;
    bits_d       = bits_q;
    ovalid_d     = ovalid_q;
    onew_d       = onew_q;
    odup_d       = odup_q;
    obeyond_d    = obeyond_q;
    odeliver_d   = odeliver_q;
    orelease_d   = orelease_q;
    oackv_d      = oackv_q;
    ostand_d     = ostand_q;
    obase_d      = obase_q;
    obits_d      = obits_q;

    // The adder idles on the advance increment unless a step needs it.
    alu_req.a   = next_exp_q;
    alu_req.b   = SeqW'(1);
    alu_req.sub = 1'b0;

    if (cfg_we_i) begin
      delay_d = cfg_data_i;
    end

    if (ovalid_q && out_o.ready) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_i.valid) begin
          op_d     = rwsa_op_e'(in_i.opcode);
          seq_d    = in_i.seq;
          unord_d  = in_i.unordered;
          now_d    = in_i.now_ms;
          new_d    = 1'b0;
          dup_d    = 1'b0;
          beyond_d = 1'b0;
          ackv_d   = 1'b0;
          stand_d  = 1'b0;
          base_d   = '0;
          bits_d   = '0;
          state_d  = StDiff;
        end
      end

      StDiff: begin
        if (op_q == OpTick) begin
          alu_req.a = now_q;
          alu_req.b = wait_start_q;
        end else begin
          alu_req.a = seq_q;
          alu_req.b = next_exp_q;
        end
        alu_req.sub = 1'b1;
        diff_d      = alu_rsp.res;
        borrow_d    = alu_rsp.borrow;
        // Every received datagram makes an ack pending; the wait starts with
        // the first one.
        if (op_q == OpDatagram) begin
          if (!ack_wait_q) begin
            wait_start_d = now_q;
          end
          ack_wait_d = 1'b1;
        end
        state_d = StClass;
      end

      StClass: begin
        state_d = StDone;
        unique case (op_q)
          OpDatagram: begin
            // A plain unsigned compare: numbers below next expected are old.
            if (borrow_q) begin
              dup_d = 1'b1;
            end else if (diff_q == '0) begin
              new_d   = 1'b1;
              state_d = StAdv;
            end else if (diff_q <= SeqW'(AckWindow)) begin
              if (bitmap_q[slot_idx]) begin
                dup_d = 1'b1;
              end else begin
                bitmap_d[slot_idx] = 1'b1;
                new_d              = 1'b1;
              end
            end else begin
              beyond_d = 1'b1;
            end
          end
          OpTick: begin
            // Standalone ack once the pending one has waited long enough.
            if (ack_wait_q && (diff_q >= {{(SeqW-DelayW){1'b0}}, delay_q})) begin
              ackv_d     = 1'b1;
              stand_d    = 1'b1;
              base_d     = next_exp_q;
              bits_d     = bitmap_ext[SeqW-1:0];
              ack_wait_d = 1'b0;
            end
          end
          OpPiggyback: begin
            if (ack_wait_q) begin
              ackv_d     = 1'b1;
              base_d     = next_exp_q;
              bits_d     = bitmap_ext[SeqW-1:0];
              ack_wait_d = 1'b0;
            end
          end
          OpUnused: begin
          end
        endcase
      end

      StAdv: begin
        // The gap is filled: move past it and past every consecutive number
        // already held in the bitmap, one per cycle.
        next_exp_d = alu_rsp.res;
        bitmap_d   = bitmap_q >> 1;
        if (!bitmap_q[0]) begin
          state_d = StDone;
        end
      end

      StDone: begin
        if (!ovalid_q || out_o.ready) begin
          ovalid_d   = 1'b1;
          onew_d     = new_q;
          odup_d     = dup_q;
          obeyond_d  = beyond_q;
          odeliver_d = new_q & unord_q;
          orelease_d = next_exp_q;
          oackv_d    = ackv_q;
          ostand_d   = stand_q;
          obase_d    = base_q;
          obits_d    = bits_q;
          state_d    = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      next_exp_q   <= '0;
      bitmap_q     <= '0;
      ack_wait_q   <= 1'b0;
      wait_start_q <= '0;
      delay_q      <= AckDelayReset;
      op_q         <= OpDatagram;
      seq_q        <= '0;
      unord_q      <= 1'b0;
      now_q        <= '0;
      diff_q       <= '0;
      borrow_q     <= 1'b0;
      new_q        <= 1'b0;
      dup_q        <= 1'b0;
      beyond_q     <= 1'b0;
      ackv_q       <= 1'b0;
      stand_q      <= 1'b0;
      base_q       <= '0;
      bits_q       <= '0;
      ovalid_q     <= 1'b0;
      onew_q       <= 1'b0;
      odup_q       <= 1'b0;
      obeyond_q    <= 1'b0;
      odeliver_q   <= 1'b0;
      orelease_q   <= '0;
      oackv_q      <= 1'b0;
      ostand_q     <= 1'b0;
      obase_q      <= '0;
      obits_q      <= '0;
    end else begin
      state_q      <= state_d;
      next_exp_q   <= next_exp_d;
      bitmap_q     <= bitmap_d;
      ack_wait_q   <= ack_wait_d;
      wait_start_q <= wait_start_d;
      delay_q      <= delay_d;
      op_q         <= op_d;
      seq_q        <= seq_d;
      unord_q      <= unord_d;
      now_q        <= now_d;
      diff_q       <= diff_d;
      borrow_q     <= borrow_d;
      new_q        <= new_d;
      dup_q        <= dup_d;
      beyond_q     <= beyond_d;
      ackv_q       <= ackv_d;
      stand_q      <= stand_d;
      base_q       <= base_d;
      bits_q       <= bits_d;
      ovalid_q     <= ovalid_d;
      onew_q       <= onew_d;
      odup_q       <= odup_d;
      obeyond_q    <= obeyond_d;
      odeliver_q   <= odeliver_d;
      orelease_q   <= orelease_d;
      oackv_q      <= oackv_d;
      ostand_q     <= ostand_d;
      obase_q      <= obase_d;
      obits_q      <= obits_d;
    end
  end

  assign out_o.valid          = ovalid_q;
  assign out_o.is_new         = onew_q;
  assign out_o.is_duplicate   = odup_q;
  assign out_o.beyond_window  = obeyond_q;
  assign out_o.deliver_now    = odeliver_q;
  assign out_o.release_below  = orelease_q;
  assign out_o.ack_valid      = oackv_q;
  assign out_o.ack_standalone = ostand_q;
  assign out_o.ack_base       = obase_q;
  assign out_o.ack_bits       = obits_q;

endmodule
